[rtl/core/npc_pkg.sv]
package npc_pkg;

   // Channel and distance widths. The largest squared distance is 3 * 255 * 255.
   localparam int CHAN_W = 8;
   localparam int FIELD5_W = 5;
   localparam int DIST_W = 18;
   localparam logic [DIST_W-1:0] DIST_START = DIST_W'(3 * 255 * 255 + 1);

   localparam int DEFAULT_PALETTE_DEPTH = 256;
   localparam int DEFAULT_SEARCH_COUNT = 255;

   typedef enum logic [1:0] {
      CMD_WRITE        = 2'd0,
      CMD_QUERY_RGB    = 2'd1,
      CMD_QUERY_PACKED = 2'd2
   } cmd_type;

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
   } rgb_type;

endpackage

[rtl/core/nearest_palette_color.sv]
// Nearest palette color search. The block holds a palette of PALETTE_DEPTH RGB
// entries in a single memory. A write word (tuser CMD_WRITE) loads one entry and
// gives no response; writes to an index beyond the palette are dropped. A query
// word gives a color either as three 8-bit channels or as a packed 15-bit color
// whose 5-bit fields are doubled. The query scans the first N entries, where N is
// the smaller of SEARCH_COUNT and PALETTE_DEPTH, one entry per cycle through
// one shared distance-and-compare unit, and answers with the lowest index at the
// minimum squared Euclidean distance plus a flag that is set when that distance
// is zero. At the default sizes the scan covers entries 0 to 254, so the
// transparent entry 255 is never chosen. A query occupies the block through the
// accepting cycle, the scan with one memory read per cycle, which sets the pace,
// and the drain of the read data register and then the channel square registers
// before the last compare. The input is not ready during a scan, nor while a
// finished response is still waiting to be taken. Only entries that have been
// written may be searched; the palette has no reset value. Unknown command codes
// are accepted and ignored.
module nearest_palette_color
   import npc_pkg::*;
#(
   parameter int PALETTE_DEPTH = DEFAULT_PALETTE_DEPTH,
   parameter int SEARCH_COUNT  = DEFAULT_SEARCH_COUNT
) (
   input  logic        clock,
   input  logic        reset,
   // Request channel.
   input  logic        req_tvalid,
   output logic        req_tready,
   // tdata fields, lowest bit first: entry_index[7:0], red[15:8], green[23:16],
   // blue[31:24], packed_color[46:32], zero fill[47].
   input  logic [47:0] req_tdata,
   // tuser fields: cmd[1:0].
   input  logic [1:0]  req_tuser,
   // Response channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // tdata fields, lowest bit first: best_index[7:0], exact_match[8], zero fill[15:9].
   output logic [15:0] rsp_tdata
);

   // The scan never runs past the end of the palette.
   localparam int SCAN_LEN = (SEARCH_COUNT < PALETTE_DEPTH) ? SEARCH_COUNT : PALETTE_DEPTH;
   localparam int ADDR_W   = $clog2(PALETTE_DEPTH);
   localparam int CNT_W    = $clog2(SCAN_LEN + 1);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_SCAN = 2'b10
   } state_type;

   state_type state_ff, state_in;

   // Request field unpacking.
   cmd_type                req_cmd;
   logic [7:0]             req_entry_index;
   rgb_type                req_rgb;
   logic [14:0]            req_packed;
   rgb_type                req_packed_rgb;
   logic                   req_accept;
   logic                   in_range;
   logic                   wr_en;
   logic [ADDR_W-1:0]      wr_addr;
   logic                   query_start;
   rgb_type                query_rgb;

   // Scan control.
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic                   issue;
   logic                   issue_last;
   logic [ADDR_W-1:0]      rd_addr;
   rgb_type                color_ff, color_in;
   rgb_type                entry_rgb;

   // Pipeline tags: stage 1 holds the memory read data, stage 2 the squares.
   logic                   p1_valid_ff;
   logic                   p1_last_ff;
   logic [ADDR_W-1:0]      p1_idx_ff;
   logic                   p2_valid_ff;
   logic                   p2_last_ff;
   logic [ADDR_W-1:0]      p2_idx_ff;

   logic [DIST_W-1:0]      sq_dist;
   logic [DIST_W-1:0]      best_ff, best_in;
   logic [ADDR_W-1:0]      best_idx_ff, best_idx_in;
   logic                   take_new;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [7:0]             rsp_index_ff, rsp_index_in;
   logic                   rsp_exact_ff, rsp_exact_in;

   assign req_cmd         = cmd_type'(req_tuser);
   assign req_entry_index = req_tdata[7:0];
   assign req_rgb.red     = req_tdata[15:8];
   assign req_rgb.green   = req_tdata[23:16];
   assign req_rgb.blue    = req_tdata[31:24];
   assign req_packed      = req_tdata[46:32];

   // Each 5-bit field of the packed color is doubled to make an 8-bit channel.
   assign req_packed_rgb.red   = {2'b00, req_packed[14:10], 1'b0};
   assign req_packed_rgb.green = {2'b00, req_packed[9:5], 1'b0};
   assign req_packed_rgb.blue  = {2'b00, req_packed[4:0], 1'b0};

   // A pending response must be taken (or be taken in this cycle) before the
   // next word is accepted, so a finishing scan never meets a full output register.
   assign req_tready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign req_accept = req_tvalid && req_tready;

   assign in_range = 32'(req_entry_index) < 32'(PALETTE_DEPTH);
   assign wr_addr  = ADDR_W'(32'(req_entry_index));

   always_comb begin
      wr_en       = 1'b0;
      query_start = 1'b0;
      query_rgb   = req_rgb;
      case (req_cmd)
         CMD_WRITE: begin
            wr_en = req_accept && in_range;
         end
         CMD_QUERY_RGB: begin
            query_start = req_accept;
         end
         CMD_QUERY_PACKED: begin
            query_start = req_accept;
            query_rgb   = req_packed_rgb;
         end
         default: begin
            wr_en       = 1'b0;
            query_start = 1'b0;
         end
      endcase
   end

   // One palette address is issued per cycle until the scan length is reached.
   assign issue      = (state_ff == ST_SCAN) && (cnt_ff < CNT_W'(SCAN_LEN));
   assign issue_last = issue && (cnt_ff == CNT_W'(SCAN_LEN - 1));
   assign rd_addr    = ADDR_W'(32'(cnt_ff));

   npc_ram #(
      .WIDTH ($bits(rgb_type)),
      .DEPTH (PALETTE_DEPTH)
   ) u_palette (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_rgb),
      .rd_en   (issue),
      .rd_addr (rd_addr),
      .rd_data (entry_rgb)
   );

   npc_dist u_dist (
      .clock   (clock),
      .query   (color_ff),
      .entry   (entry_rgb),
      .sq_dist (sq_dist)
   );

   // A strict compare keeps the first entry at the minimum distance.
   assign take_new = p2_valid_ff && (sq_dist < best_ff);

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      color_in     = color_ff;
      best_in      = best_ff;
      best_idx_in  = best_idx_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_index_in = rsp_index_ff;
      rsp_exact_in = rsp_exact_ff;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      if (issue) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end

      if (take_new) begin
         best_in     = sq_dist;
         best_idx_in = p2_idx_ff;
      end

      case (state_ff)
         ST_IDLE: begin
            if (query_start) begin
               state_in    = ST_SCAN;
               cnt_in      = '0;
               color_in    = query_rgb;
               best_in     = DIST_START;
               best_idx_in = '0;
            end
         end
         ST_SCAN: begin
            if (p2_valid_ff && p2_last_ff) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               rsp_index_in = 8'(32'(best_idx_in));
               rsp_exact_in = (best_in == '0);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         p1_valid_ff  <= 1'b0;
         p2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         p1_valid_ff  <= issue;
         p2_valid_ff  <= p1_valid_ff;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      color_ff     <= color_in;
      best_ff      <= best_in;
      best_idx_ff  <= best_idx_in;
      p1_last_ff   <= issue_last;
      p1_idx_ff    <= rd_addr;
      p2_last_ff   <= p1_last_ff;
      p2_idx_ff    <= p1_idx_ff;
      rsp_index_ff <= rsp_index_in;
      rsp_exact_ff <= rsp_exact_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'b0000000, rsp_exact_ff, rsp_index_ff};

   // Compare results only arrive while a scan is in progress.
   assert property (@(posedge clock) disable iff (reset)
      p2_valid_ff |-> (state_ff == ST_SCAN))
      else $error("distance result outside of a scan");

   // A response appears only when the last entry of a scan has been compared.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(p2_valid_ff && p2_last_ff))
      else $error("response raised before the scan finished");

   // The running minimum never exceeds its starting value during a scan.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (best_ff <= DIST_START))
      else $error("running minimum out of range");

   // A finishing scan never finds the output register still occupied.
   assert property (@(posedge clock) disable iff (reset)
      (p2_valid_ff && p2_last_ff) |-> !rsp_valid_ff)
      else $error("response overwritten before it was taken");

   // The last-entry marker is in at most one pipeline stage at a time.
   assert property (@(posedge clock) disable iff (reset)
      $onehot0({issue_last, p1_valid_ff && p1_last_ff, p2_valid_ff && p2_last_ff}))
      else $error("more than one scan end in flight");

endmodule

[rtl/core/npc_ram.sv]
module npc_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/npc_dist.sv]
// Squared Euclidean distance unit. The three channel squares are registered,
// and their sum is formed in the following cycle.
module npc_dist
   import npc_pkg::*;
(
   input  logic              clock,
   input  rgb_type           query,
   input  rgb_type           entry,
   output logic [DIST_W-1:0] sq_dist
);

   logic [CHAN_W-1:0]   diff_r;
   logic [CHAN_W-1:0]   diff_g;
   logic [CHAN_W-1:0]   diff_b;
   logic [2*CHAN_W-1:0] sq_r_ff;
   logic [2*CHAN_W-1:0] sq_g_ff;
   logic [2*CHAN_W-1:0] sq_b_ff;

   always_comb begin
      diff_r = (query.red > entry.red) ? (query.red - entry.red) : (entry.red - query.red);
      diff_g = (query.green > entry.green) ? (query.green - entry.green)
                                           : (entry.green - query.green);
      diff_b = (query.blue > entry.blue) ? (query.blue - entry.blue)
                                         : (entry.blue - query.blue);
   end

   always_ff @(posedge clock) begin
      sq_r_ff <= diff_r * diff_r;
      sq_g_ff <= diff_g * diff_g;
      sq_b_ff <= diff_b * diff_b;
   end

   assign sq_dist = DIST_W'(sq_r_ff) + DIST_W'(sq_g_ff) + DIST_W'(sq_b_ff);

endmodule
